// File: design/idd_pkg.sv
// Shared widths and codes for the incremental deadlock detector.
// Depends on nothing; the top level and the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package idd_pkg;

   // Fixed widths of the request and response fields.
   localparam int ID_WIDTH   = 5;
   localparam int MASK_WIDTH = 32;
   localparam int EDGE_WIDTH = 16;

   // Edge kind codes carried on req_kind.
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_ASSIGN  = 1'b1;

endpackage

`default_nettype wire

// File: design/idd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the graph's row store.
`timescale 1ns / 1ps
`default_nettype none

module idd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/incremental_deadlock_detector.sv
// Top level of the incremental deadlock detector: row store, peeling sequencer, result beat.
// Depends on idd_pkg and idd_ram.
//
// Each beat accepted on start (while busy is low) adds one edge to a resource
// allocation graph and answers with one result beat: rsp_valid is high for exactly
// one cycle, and the receiver cannot stall it. Request edges (process to resource)
// and assignment edges (resource to process) live as bit rows in one RAM, process
// rows first, then resource rows; per-row valid flops make the whole store read as
// empty right after reset, so there is no clearing sweep. Deadlock is found by
// peeling: one shared masked OR-reduce unit tests one row per cycle against the surviving
// set, and full passes over all NUM_PROCS + NUM_RES rows repeat until a pass removes
// nothing, so an item takes at least one pass. Edges whose ids are not below NUM_PROCS
// or NUM_RES are not stored but still take an edge index; the index saturates at its
// maximum.
`timescale 1ns / 1ps
`default_nettype none

module incremental_deadlock_detector #(
   parameter int NUM_PROCS = 32,
   parameter int NUM_RES   = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_kind,
   input  wire logic [idd_pkg::ID_WIDTH-1:0]     req_process_id,
   input  wire logic [idd_pkg::ID_WIDTH-1:0]     req_resource_id,
   output logic                                  rsp_valid,
   output logic                                  rsp_deadlock,
   output logic      [idd_pkg::MASK_WIDTH-1:0]   rsp_deadlocked_mask,
   output logic      [idd_pkg::EDGE_WIDTH-1:0]   rsp_edge_index
);

   import idd_pkg::*;

   localparam int Rows      = NUM_PROCS + NUM_RES;
   localparam int AddrWidth = $clog2(Rows);
   localparam int RowWidth  = (NUM_PROCS > NUM_RES) ? NUM_PROCS : NUM_RES;
   localparam int PosWidth  = $clog2(RowWidth);
   localparam int PidxWidth = $clog2(NUM_PROCS);
   localparam int RidxWidth = $clog2(NUM_RES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WRITE,
      S_SWEEP
   } state_type;

   state_type                state_ff, state_in;
   logic                     kind_ff, kind_in;
   logic [ID_WIDTH-1:0]      pid_ff, pid_in;
   logic [ID_WIDTH-1:0]      rid_ff, rid_in;
   logic                     in_range_ff, in_range_in;
   logic [Rows-1:0]          row_valid_ff, row_valid_in;
   logic [NUM_PROCS-1:0]     live_p_ff, live_p_in;
   logic [NUM_RES-1:0]       live_r_ff, live_r_in;
   logic [AddrWidth-1:0]     iss_addr_ff, iss_addr_in;
   logic                     iss_en_ff, iss_en_in;
   logic [AddrWidth-1:0]     chk_addr_ff, chk_addr_in;
   logic                     chk_en_ff, chk_en_in;
   logic                     chk_row_valid_ff, chk_row_valid_in;
   logic                     changed_ff, changed_in;
   logic [EDGE_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_deadlock_ff, rsp_deadlock_in;
   logic [MASK_WIDTH-1:0]    rsp_mask_ff, rsp_mask_in;
   logic [EDGE_WIDTH-1:0]    rsp_edge_ff, rsp_edge_in;

   logic                     accept;
   logic [AddrWidth-1:0]     target_row;
   logic [PosWidth-1:0]      target_pos;
   logic                     ram_wr_en;
   logic [RowWidth-1:0]      ram_wr_data;
   logic                     ram_rd_en;
   logic [AddrWidth-1:0]     ram_rd_addr;
   logic [RowWidth-1:0]      ram_rd_data;
   logic [RowWidth-1:0]      row_data;
   logic                     is_proc_row;
   logic [PidxWidth-1:0]     pidx;
   logic [RidxWidth-1:0]     ridx;
   logic [RowWidth-1:0]      live_sel;
   logic                     row_hit;
   logic                     node_live;
   logic                     removed;
   logic                     last_check;
   logic [NUM_PROCS+MASK_WIDTH-1:0] mask_wide;

   assign accept = start && (state_ff == S_IDLE);

   // Row and bit position of the latched edge.
   assign target_row = (kind_ff == KIND_ASSIGN) ?
                       AddrWidth'(NUM_PROCS) + AddrWidth'(rid_ff) : AddrWidth'(pid_ff);
   assign target_pos = (kind_ff == KIND_ASSIGN) ? PosWidth'(pid_ff) : PosWidth'(rid_ff);

   // A row never written reads as empty.
   assign row_data = chk_row_valid_ff ? ram_rd_data : '0;

   // Shared row test: does this row reach any surviving node on the other side?
   assign is_proc_row = chk_addr_ff < AddrWidth'(NUM_PROCS);
   assign pidx        = chk_addr_ff[PidxWidth-1:0];
   assign ridx        = RidxWidth'(chk_addr_ff - AddrWidth'(NUM_PROCS));
   assign live_sel    = is_proc_row ? RowWidth'(live_r_ff) : RowWidth'(live_p_ff);
   assign row_hit     = |(row_data & live_sel);
   assign node_live   = is_proc_row ? live_p_ff[pidx] : live_r_ff[ridx];
   assign removed     = chk_en_ff && node_live && !row_hit;
   assign last_check  = chk_en_ff && (chk_addr_ff == AddrWidth'(Rows - 1));

   assign mask_wide = {{MASK_WIDTH{1'b0}}, live_p_ff};

   // RAM port control: read-modify-write of one row, then streamed sweep reads.
   assign ram_wr_en   = (state_ff == S_WRITE) && in_range_ff;
   assign ram_wr_data = row_data | ({{(RowWidth-1){1'b0}}, 1'b1} << target_pos);
   assign ram_rd_en   = (state_ff == S_READ) || ((state_ff == S_SWEEP) && iss_en_ff);
   assign ram_rd_addr = (state_ff == S_READ) ? target_row : iss_addr_ff;

   idd_ram #(
      .WIDTH (RowWidth),
      .DEPTH (Rows)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (target_row),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer next state.
   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      pid_in           = pid_ff;
      rid_in           = rid_ff;
      in_range_in      = in_range_ff;
      row_valid_in     = row_valid_ff;
      live_p_in        = live_p_ff;
      live_r_in        = live_r_ff;
      iss_addr_in      = iss_addr_ff;
      iss_en_in        = iss_en_ff;
      chk_addr_in      = chk_addr_ff;
      chk_en_in        = 1'b0;
      chk_row_valid_in = chk_row_valid_ff;
      changed_in       = changed_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = 1'b0;
      rsp_deadlock_in  = rsp_deadlock_ff;
      rsp_mask_in      = rsp_mask_ff;
      rsp_edge_in      = rsp_edge_ff;

      if (ram_rd_en) begin
         chk_row_valid_in = row_valid_ff[ram_rd_addr];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in     = req_kind;
               pid_in      = req_process_id;
               rid_in      = req_resource_id;
               in_range_in = ({1'b0, req_process_id} < (ID_WIDTH + 1)'(NUM_PROCS)) &&
                             ({1'b0, req_resource_id} < (ID_WIDTH + 1)'(NUM_RES));
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // Old row is back from the RAM; merge in the new bit and start peeling.
            if (in_range_ff) begin
               row_valid_in[target_row] = 1'b1;
            end
            live_p_in   = '1;
            live_r_in   = '1;
            iss_addr_in = '0;
            iss_en_in   = 1'b1;
            changed_in  = 1'b0;
            state_in    = S_SWEEP;
         end
         S_SWEEP: begin
            // Issue side walks the rows once per pass.
            chk_en_in   = iss_en_ff;
            chk_addr_in = iss_addr_ff;
            if (iss_en_ff) begin
               if (iss_addr_ff == AddrWidth'(Rows - 1)) begin
                  iss_en_in = 1'b0;
               end else begin
                  iss_addr_in = iss_addr_ff + 1'b1;
               end
            end
            // Check side drops a node that reaches no survivor.
            if (removed) begin
               if (is_proc_row) begin
                  live_p_in[pidx] = 1'b0;
               end else begin
                  live_r_in[ridx] = 1'b0;
               end
            end
            changed_in = changed_ff || removed;
            // End of pass: run again if anything changed, else report.
            if (last_check) begin
               if (changed_ff || removed) begin
                  iss_addr_in = '0;
                  iss_en_in   = 1'b1;
                  changed_in  = 1'b0;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_deadlock_in = |live_p_ff;
                  rsp_mask_in     = mask_wide[MASK_WIDTH-1:0];
                  rsp_edge_in     = cnt_ff;
                  if (cnt_ff != '1) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, store bookkeeping and registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         iss_en_ff    <= 1'b0;
         chk_en_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         iss_en_ff    <= iss_en_in;
         chk_en_ff    <= chk_en_in;
         changed_ff   <= changed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff          <= kind_in;
      pid_ff           <= pid_in;
      rid_ff           <= rid_in;
      in_range_ff      <= in_range_in;
      live_p_ff        <= live_p_in;
      live_r_ff        <= live_r_in;
      iss_addr_ff      <= iss_addr_in;
      chk_addr_ff      <= chk_addr_in;
      chk_row_valid_ff <= chk_row_valid_in;
      rsp_deadlock_ff  <= rsp_deadlock_in;
      rsp_mask_ff      <= rsp_mask_in;
      rsp_edge_ff      <= rsp_edge_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_deadlock        = rsp_deadlock_ff;
   assign rsp_deadlocked_mask = rsp_mask_ff;
   assign rsp_edge_index      = rsp_edge_ff;

endmodule

`default_nettype wire

// File: design/idd_checker.sv
// Port-level checks for the incremental deadlock detector, bound to its top level.
// Depends on idd_pkg and incremental_deadlock_detector.
`timescale 1ns / 1ps
`default_nettype none

module idd_checker #(
   parameter int NUM_PROCS = 32
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_deadlock,
   input wire logic [idd_pkg::MASK_WIDTH-1:0]   rsp_deadlocked_mask
);

   import idd_pkg::*;

   // An accepted beat makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // A result beat ends the work of the item that was in flight.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result beat without a preceding busy period");

   // Each item passes through the read, write and sweep states, so result beats never come back to back.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beats on consecutive cycles");

   // With every process visible in the mask, the flag matches the mask.
   a_flag_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (NUM_PROCS <= MASK_WIDTH)) |->
         (rsp_deadlock == (rsp_deadlocked_mask != '0)))
      else $error("deadlock flag disagrees with deadlocked mask");

endmodule

bind incremental_deadlock_detector idd_checker #(
   .NUM_PROCS (NUM_PROCS)
) u_idd_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_deadlock        (rsp_deadlock),
   .rsp_deadlocked_mask (rsp_deadlocked_mask)
);

`default_nettype wire
